/* rtl/cdc_pkg.sv */
package cdc_pkg;

    // request codes carried in func
    localparam logic [1:0] FUNC_SYNC  = 2'd0;
    localparam logic [1:0] FUNC_QUERY = 2'd1;
    localparam logic [1:0] FUNC_SET   = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EPOCH_FLOOR  = 4'd1;

    // register reset values
    localparam logic [31:0] MIN_INTERVAL_RESET = 32'd10000;
    localparam logic [63:0] EPOCH_FLOOR_RESET  = 64'd1700000000000;

    // drift limits and scaling
    localparam logic signed [31:0] DRIFT_LIMIT     = 32'sd3276700;
    localparam logic signed [31:0] DRIFT_LIMIT_NEG = -32'sd3276700;
    localparam logic [31:0] PPM_SCALE = 32'd1000000;

    // divide by 100 as multiply by ceil(2^29/100) then shift, exact below 2^22
    localparam logic [31:0] RECIP_100   = 32'd5368710;
    localparam int unsigned RECIP_SHIFT = 29;

    // products stay below 2^86, divisors below 2^64
    localparam int unsigned DVD_W = 86;
    localparam int unsigned DVS_W = 64;
    localparam int unsigned MUL_W = 32;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPAN,
        ST_TEST,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_SUM,
        ST_DIV_WAIT,
        ST_SAT,
        ST_SMOOTH,
        ST_CLAMP,
        ST_RECIP,
        ST_STORE,
        ST_CORR,
        ST_FINISH
    } state_t;

    // strobes from the sequencer to the datapath
    typedef struct packed {
        logic in_ready;
        logic load_in;
        logic calc_span;
        logic calc_test;
        logic mul_lo;
        logic mul_hi;
        logic div_start;
        logic sat;
        logic smooth;
        logic clamp;
        logic recip;
        logic store;
        logic corr;
        logic finish;
    } ctrl_t;

    // conditions from the datapath to the sequencer
    typedef struct packed {
        logic       req_valid;
        logic [1:0] func;
        logic       usable;
        logic       span_ok;
        logic       query_ok;
        logic       div_busy;
        logic       out_free;
    } status_t;

endpackage

/* rtl/cdc_if.sv */
// request channel
interface cdc_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [63:0]        timer_ms;
    logic [63:0]        accurate_ms;
    logic signed [31:0] drift_value;

    modport source (output valid, func, timer_ms, accurate_ms, drift_value, input ready);
    modport sink   (input valid, func, timer_ms, accurate_ms, drift_value, output ready);
endinterface

// result channel
interface cdc_rsp_if;
    logic               valid;
    logic               ready;
    logic [63:0]        time_ms;
    logic               timer_load;
    logic signed [22:0] drift_now;
    logic               drift_known;

    modport source (output valid, time_ms, timer_load, drift_now, drift_known, input ready);
    modport sink   (input valid, time_ms, timer_load, drift_now, drift_known, output ready);
endinterface

// configuration write channel
interface cdc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cdc_pkg::CFG_IDX_W-1:0]  index;
    logic [63:0]                    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/cdc_mul.sv */
module cdc_mul #(
    parameter int unsigned W = 32
) (
    input  logic           clk,
    input  logic           en,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic [2*W-1:0] p
);

    logic [2*W-1:0] p_reg;

    // registered product, held between issues
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule

/* rtl/cdc_div.sv */
module cdc_div #(
    parameter int unsigned DVD_W = 86,
    parameter int unsigned DVS_W = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [DVD_W-1:0] quotient
);

    localparam int unsigned CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   trial_sub;
    logic             take;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        trial_sub = trial - {1'b0, dvs_reg};
        take      = (trial >= {1'b0, dvs_reg});
    end

    // step sequencing
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = take ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], take};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/cdc_fsm.sv */
module cdc_fsm (
    input  logic             clk,
    input  logic             rst_n,
    input  cdc_pkg::status_t sts,
    output cdc_pkg::ctrl_t   ctrl
);

    cdc_pkg::state_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cdc_pkg::ST_IDLE:
            begin
                if (sts.req_valid)
                begin
                    state_next = cdc_pkg::ST_SPAN;
                end
            end
            cdc_pkg::ST_SPAN:
            begin
                state_next = cdc_pkg::ST_TEST;
            end
            cdc_pkg::ST_TEST:
            begin
                case (sts.func)
                    cdc_pkg::FUNC_SYNC:
                    begin
                        state_next = (sts.usable && sts.span_ok) ? cdc_pkg::ST_MUL_LO
                                                                 : cdc_pkg::ST_FINISH;
                    end
                    cdc_pkg::FUNC_QUERY:
                    begin
                        state_next = sts.query_ok ? cdc_pkg::ST_MUL_LO : cdc_pkg::ST_FINISH;
                    end
                    cdc_pkg::FUNC_SET:
                    begin
                        state_next = cdc_pkg::ST_CLAMP;
                    end
                    default:
                    begin
                        state_next = cdc_pkg::ST_FINISH;
                    end
                endcase
            end
            cdc_pkg::ST_MUL_LO:
            begin
                state_next = cdc_pkg::ST_MUL_HI;
            end
            cdc_pkg::ST_MUL_HI:
            begin
                state_next = cdc_pkg::ST_MUL_SUM;
            end
            cdc_pkg::ST_MUL_SUM:
            begin
                state_next = cdc_pkg::ST_DIV_WAIT;
            end
            cdc_pkg::ST_DIV_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    state_next = (sts.func == cdc_pkg::FUNC_SYNC) ? cdc_pkg::ST_SAT
                                                                  : cdc_pkg::ST_CORR;
                end
            end
            cdc_pkg::ST_SAT:
            begin
                state_next = cdc_pkg::ST_SMOOTH;
            end
            cdc_pkg::ST_SMOOTH:
            begin
                state_next = cdc_pkg::ST_CLAMP;
            end
            cdc_pkg::ST_CLAMP:
            begin
                state_next = cdc_pkg::ST_RECIP;
            end
            cdc_pkg::ST_RECIP:
            begin
                state_next = cdc_pkg::ST_STORE;
            end
            cdc_pkg::ST_STORE:
            begin
                state_next = cdc_pkg::ST_FINISH;
            end
            cdc_pkg::ST_CORR:
            begin
                state_next = cdc_pkg::ST_FINISH;
            end
            cdc_pkg::ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = cdc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cdc_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath strobes
    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            cdc_pkg::ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                ctrl.load_in  = sts.req_valid;
            end
            cdc_pkg::ST_SPAN:     ctrl.calc_span = 1'b1;
            cdc_pkg::ST_TEST:     ctrl.calc_test = 1'b1;
            cdc_pkg::ST_MUL_LO:   ctrl.mul_lo    = 1'b1;
            cdc_pkg::ST_MUL_HI:   ctrl.mul_hi    = 1'b1;
            cdc_pkg::ST_MUL_SUM:  ctrl.div_start = 1'b1;
            cdc_pkg::ST_SAT:      ctrl.sat       = 1'b1;
            cdc_pkg::ST_SMOOTH:   ctrl.smooth    = 1'b1;
            cdc_pkg::ST_CLAMP:    ctrl.clamp     = 1'b1;
            cdc_pkg::ST_RECIP:    ctrl.recip     = 1'b1;
            cdc_pkg::ST_STORE:    ctrl.store     = 1'b1;
            cdc_pkg::ST_CORR:     ctrl.corr      = 1'b1;
            cdc_pkg::ST_FINISH:   ctrl.finish    = sts.out_free;
            default:              ctrl = '0;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cdc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/clock_drift_compensator.sv */
// channel  role    width of payload                      handshake
// req      sink    func 2, timer_ms 64, accurate_ms 64,  valid/ready
//                  drift_value 32 signed
// rsp      source  time_ms 64, timer_load 1,             valid/ready
//                  drift_now 23 signed, drift_known 1
// cfg      sink    index 4, data 64                      valid/ready, ready always high
//
// one request at a time: a sync with drift measurement and a corrected query
// both wait on the 86-step restoring divider, which set drift and other
// requests do not use; req.ready is high only while idle; the result sits in
// an output register so a stalled rsp holds at most one request in its final
// state; reset clears the sync point, the stored drift and the configuration
// registers to defaults
module clock_drift_compensator (
    input  logic      clk,
    input  logic      rst_n,
    cdc_req_if.sink   req,
    cdc_rsp_if.source rsp,
    cdc_cfg_if.sink   cfg
);

    cdc_pkg::ctrl_t   ctrl;
    cdc_pkg::status_t sts;

    // configuration and persistent state
    logic [31:0]        min_interval_reg;
    logic [63:0]        epoch_floor_reg;
    logic [63:0]        sync_timer_reg;
    logic [63:0]        sync_acc_reg;
    logic signed [15:0] drift_code_reg;
    logic               drift_valid_reg;

    // captured request
    logic [1:0]         func_reg;
    logic [63:0]        timer_reg;
    logic [63:0]        acc_reg;
    logic signed [31:0] dv_reg;

    // working registers
    logic [63:0]        ts_reg;
    logic [63:0]        ns_reg;
    logic               usable_reg;
    logic               sign_reg;
    logic [63:0]        a_reg;
    logic [31:0]        b_reg;
    logic [63:0]        divisor_reg;
    logic [63:0]        base_reg;
    logic [63:0]        lo_reg;
    logic signed [31:0] meas_reg;
    logic signed [31:0] nd_reg;
    logic [22:0]        clamp_reg;
    logic [63:0]        time_reg;

    // output register
    logic               out_valid_reg;
    logic [63:0]        out_time_reg;
    logic               out_load_reg;
    logic signed [22:0] out_drift_reg;
    logic               out_known_reg;

    // shared units
    logic [cdc_pkg::MUL_W-1:0]   mul_a;
    logic [cdc_pkg::MUL_W-1:0]   mul_b;
    logic [2*cdc_pkg::MUL_W-1:0] mul_p;
    logic                        mul_en;
    logic [cdc_pkg::DVD_W-1:0]   dividend;
    logic [cdc_pkg::DVD_W-1:0]   quo;
    logic                        div_busy;

    // combinational helpers
    logic signed [22:0] drift_ext;
    logic signed [22:0] drift_eff;
    logic signed [22:0] drift_now_w;
    logic [22:0]        drift_abs;
    logic [22:0]        clamp_abs;
    logic               ts_gt;
    logic               ns_gt;
    logic               diff_neg;
    logic               qhi_nz;
    logic signed [31:0] meas_w;
    logic signed [33:0] old_x;
    logic signed [33:0] meas_x;
    logic signed [33:0] sum3;
    logic signed [33:0] sum_adj;
    logic signed [33:0] quarter;
    logic [22:0]        clamp_w;
    logic [15:0]        q16;
    logic [15:0]        code_w;
    logic               out_free;

    // effective drift in ppm: code * 100 as shifts and adds
    always_comb
    begin
        drift_ext   = {{7{drift_code_reg[15]}}, drift_code_reg};
        drift_eff   = (drift_ext <<< 6) + (drift_ext <<< 5) + (drift_ext <<< 2);
        drift_now_w = drift_valid_reg ? drift_eff : 23'sd0;
        drift_abs   = drift_eff[22] ? (23'd0 - drift_eff) : drift_eff;
        clamp_abs   = clamp_reg[22] ? (23'd0 - clamp_reg) : clamp_reg;
    end

    // span checks, both spans read as signed
    always_comb
    begin
        ts_gt    = !ts_reg[63] && (ts_reg > {32'd0, min_interval_reg});
        ns_gt    = !ns_reg[63] && (ns_reg > {32'd0, min_interval_reg});
        diff_neg = (ns_reg < ts_reg);
    end

    // saturate the measured drift to 32 bits signed
    always_comb
    begin
        qhi_nz = |quo[cdc_pkg::DVD_W-1:32];
        if (sign_reg)
        begin
            meas_w = (qhi_nz || (quo[31:0] > 32'h8000_0000)) ? 32'sh8000_0000
                                                             : $signed(32'd0 - quo[31:0]);
        end
        else
        begin
            meas_w = (qhi_nz || quo[31]) ? 32'sh7FFF_FFFF : $signed(quo[31:0]);
        end
    end

    // 3:1 smoothing, truncated toward zero
    always_comb
    begin
        old_x   = {{11{drift_now_w[22]}}, drift_now_w};
        meas_x  = {{2{meas_reg[31]}}, meas_reg};
        sum3    = (old_x <<< 1) + old_x + meas_x;
        sum_adj = sum3 + (sum3[33] ? 34'sd3 : 34'sd0);
        quarter = sum_adj >>> 2;
    end

    // clamp to the drift limit
    always_comb
    begin
        if (nd_reg > cdc_pkg::DRIFT_LIMIT)
        begin
            clamp_w = cdc_pkg::DRIFT_LIMIT[22:0];
        end
        else if (nd_reg < cdc_pkg::DRIFT_LIMIT_NEG)
        begin
            clamp_w = cdc_pkg::DRIFT_LIMIT_NEG[22:0];
        end
        else
        begin
            clamp_w = nd_reg[22:0];
        end
    end

    // code from the reciprocal product, sign restored
    always_comb
    begin
        q16    = mul_p[cdc_pkg::RECIP_SHIFT +: 16];
        code_w = clamp_reg[22] ? (16'd0 - q16) : q16;
    end

    // multiplier operands
    always_comb
    begin
        mul_en = ctrl.mul_lo || ctrl.mul_hi || ctrl.recip;
        if (ctrl.mul_lo)
        begin
            mul_a = a_reg[31:0];
        end
        else if (ctrl.mul_hi)
        begin
            mul_a = a_reg[63:32];
        end
        else
        begin
            mul_a = {10'd0, clamp_abs[21:0]};
        end
        mul_b = ctrl.recip ? cdc_pkg::RECIP_100 : b_reg;
    end

    // partial products fall below 2^54
    assign dividend = {mul_p[53:0], 32'd0} + {22'd0, lo_reg};

    // status to the sequencer
    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        sts.req_valid = req.valid;
        sts.func      = func_reg;
        sts.usable    = usable_reg;
        sts.span_ok   = ts_gt && ns_gt;
        sts.query_ok  = usable_reg && (drift_code_reg != 16'sd0);
        sts.div_busy  = div_busy;
        sts.out_free  = out_free;
    end

    cdc_fsm u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .ctrl  (ctrl)
    );

    cdc_mul #(
        .W (cdc_pkg::MUL_W)
    ) u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    cdc_div #(
        .DVD_W (cdc_pkg::DVD_W),
        .DVS_W (cdc_pkg::DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .dividend (dividend),
        .divisor  (divisor_reg),
        .busy     (div_busy),
        .quotient (quo)
    );

    // configuration writes, sync point and stored drift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg <= cdc_pkg::MIN_INTERVAL_RESET;
            epoch_floor_reg  <= cdc_pkg::EPOCH_FLOOR_RESET;
            sync_timer_reg   <= '0;
            sync_acc_reg     <= '0;
            drift_code_reg   <= '0;
            drift_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    cdc_pkg::REG_MIN_INTERVAL: min_interval_reg <= cfg.data[31:0];
                    cdc_pkg::REG_EPOCH_FLOOR:  epoch_floor_reg  <= cfg.data;
                    default:                   ;
                endcase
            end
            if (ctrl.store)
            begin
                drift_code_reg  <= $signed(code_w);
                drift_valid_reg <= 1'b1;
            end
            if (ctrl.finish && (func_reg == cdc_pkg::FUNC_SYNC))
            begin
                sync_timer_reg <= timer_reg;
                sync_acc_reg   <= acc_reg;
            end
        end
    end

    // request capture and working datapath
    always_ff @(posedge clk)
    begin
        if (ctrl.load_in)
        begin
            func_reg  <= req.func;
            timer_reg <= req.timer_ms;
            acc_reg   <= req.accurate_ms;
            dv_reg    <= req.drift_value;
        end
        if (ctrl.calc_span)
        begin
            ts_reg     <= timer_reg - sync_timer_reg;
            ns_reg     <= acc_reg - sync_acc_reg;
            usable_reg <= drift_valid_reg && (sync_timer_reg != 64'd0)
                          && (sync_acc_reg > epoch_floor_reg);
        end
        if (ctrl.calc_test)
        begin
            case (func_reg)
                cdc_pkg::FUNC_SYNC:
                begin
                    a_reg       <= diff_neg ? (ts_reg - ns_reg) : (ns_reg - ts_reg);
                    b_reg       <= cdc_pkg::PPM_SCALE;
                    divisor_reg <= ts_reg;
                    sign_reg    <= diff_neg;
                    time_reg    <= acc_reg;
                end
                cdc_pkg::FUNC_QUERY:
                begin
                    a_reg       <= ts_reg[63] ? (64'd0 - ts_reg) : ts_reg;
                    b_reg       <= {10'd0, drift_abs[21:0]};
                    divisor_reg <= {32'd0, cdc_pkg::PPM_SCALE};
                    sign_reg    <= ts_reg[63] ^ drift_eff[22];
                    base_reg    <= sync_acc_reg + ts_reg;
                    time_reg    <= timer_reg;
                end
                cdc_pkg::FUNC_SET:
                begin
                    nd_reg   <= dv_reg;
                    time_reg <= '0;
                end
                default:
                begin
                    time_reg <= '0;
                end
            endcase
        end
        if (ctrl.mul_hi)
        begin
            lo_reg <= mul_p;
        end
        if (ctrl.sat)
        begin
            meas_reg <= meas_w;
        end
        if (ctrl.smooth)
        begin
            nd_reg <= (drift_now_w == 23'sd0) ? meas_reg : quarter[31:0];
        end
        if (ctrl.clamp)
        begin
            clamp_reg <= clamp_w;
        end
        if (ctrl.corr)
        begin
            time_reg <= sign_reg ? (base_reg - quo[63:0]) : (base_reg + quo[63:0]);
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            out_time_reg  <= time_reg;
            out_load_reg  <= (func_reg == cdc_pkg::FUNC_SYNC);
            out_drift_reg <= drift_now_w;
            out_known_reg <= drift_valid_reg;
        end
    end

    assign req.ready       = ctrl.in_ready;
    assign cfg.ready       = 1'b1;
    assign rsp.valid       = out_valid_reg;
    assign rsp.time_ms     = out_time_reg;
    assign rsp.timer_load  = out_load_reg;
    assign rsp.drift_now   = out_drift_reg;
    assign rsp.drift_known = out_known_reg;

endmodule

/* rtl/cdc_checker.sv */
module cdc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [63:0] rsp_time_ms,
    input logic [22:0] rsp_drift_now,
    input logic        rsp_drift_known
);

    // one request at a time: ready drops after each transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req.ready stayed high after a transaction");

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_time_ms)
                                    && $stable(rsp_drift_now))
        else $error("stalled result changed");

    // no drift reported before one is stored
    a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_drift_known |-> rsp_drift_now == 23'd0)
        else $error("drift reported while not known");

    // reported drift stays inside the clamp limit
    a_drift_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ($signed(rsp_drift_now) <= 23'sd3276700)
                      && ($signed(rsp_drift_now) >= -23'sd3276700))
        else $error("drift outside limit");

endmodule

bind clock_drift_compensator cdc_checker u_cdc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_time_ms     (rsp.time_ms),
    .rsp_drift_now   (rsp.drift_now),
    .rsp_drift_known (rsp.drift_known)
);
